@@ hw/rtl/twin_presence_shelf_life_monitor_top_macros.svh @@
// Assertion macros for the monitor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TWIN_PRESENCE_SHELF_LIFE_MONITOR_TOP_MACROS_SVH
`define TWIN_PRESENCE_SHELF_LIFE_MONITOR_TOP_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define TPSLM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpslm assertion failed");

// Consequent checked in the cycle after the antecedent.
`define TPSLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpslm assertion failed");

`endif

@@ hw/rtl/tpslm_pkg.sv @@
// Package for the twin presence and shelf-life monitor: beat types, codes and constants.
// Depends on nothing; used by tpslm_core and the top level.
package tpslm_pkg;

    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_HEARTBEAT = 3'd1;
    localparam logic [2:0] ACT_FORCE     = 3'd2;
    localparam logic [2:0] ACT_REPORT    = 3'd3;
    localparam logic [2:0] ACT_OFFLINE   = 3'd4;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_LINK_ERR = 2'd1;
    localparam logic [1:0] EV_CLEARED  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_WARMUP  = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;

    localparam logic [15:0] PRESENT_EVENT_AT = 16'd10;
    localparam logic [14:0] LOST_DROP_AT     = 15'd3;
    localparam logic [14:0] LOST_CLEAR_AT    = 15'd4;
    localparam logic [15:0] FOLD_ABOVE       = 16'd20000;
    localparam logic [15:0] FOLD_TO          = 16'd10000;
    localparam logic [14:0] LOST_FOLD_ABOVE  = 15'd20000;
    localparam logic [14:0] LOST_FOLD_TO     = 15'd10000;
    localparam logic [7:0]  CORRECT_PHASE    = 8'd1;
    localparam logic [15:0] STALE_ABOVE      = 16'd300;
    localparam logic [31:0] WARMUP_BELOW     = 32'd70;
    localparam logic [14:0] LOST_RESET       = 15'd100;
    localparam logic [16:0] ADOPT_MARGIN     = 17'd10;
    localparam logic [15:0] ADOPT_LIMIT      = 16'd10000;

    typedef struct packed {
        logic [2:0]  action;
        logic        twin_present;
        logic        length_ok;
        logic [15:0] peer_own_uptime;
        logic [15:0] peer_seen_uptime;
        logic [31:0] peer_run_seconds;
        logic [15:0] force_value;
    } item_t;

    typedef struct packed {
        logic [1:0]  event_code;
        logic [1:0]  status;
        logic [15:0] own_uptime;
        logic [15:0] twin_uptime;
        logic [15:0] freshness;
        logic [31:0] twin_run;
    } result_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hffff) ? v : v + 16'd1;
    endfunction

endpackage

@@ hw/rtl/twin_presence_shelf_life_monitor_top.sv @@
// Top level of the twin presence and shelf-life monitor: input and result registers.
// Depends on tpslm_pkg and tpslm_core.
//
//  Channel | Valid        | Stall        | Beat
//  --------+--------------+--------------+---------------------------
//  input   | item_valid   | item_stall   | item (tpslm_pkg::item_t)
//  result  | res_valid    | res_stall    | res  (tpslm_pkg::result_t)
//
// Items go through the input and result registers; one is accepted per cycle unless stalled.
// The state update happens as the item moves from the input register into the result register.
// A stalled result holds; the input register then fills and item_stall rises.
// Reset empties both registers and loads the counters with their start values.
module twin_presence_shelf_life_monitor_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  tpslm_pkg::item_t   item,
    output logic               res_valid,
    input  logic               res_stall,
    output tpslm_pkg::result_t res
);

    logic               in_valid_reg;
    logic               in_valid_next;
    tpslm_pkg::item_t   in_reg;
    logic               res_valid_reg;
    logic               res_valid_next;
    tpslm_pkg::result_t res_reg;
    tpslm_pkg::result_t core_res;
    logic               adv;
    logic               take;

    assign adv        = in_valid_reg && (!res_valid_reg || !res_stall);
    assign item_stall = in_valid_reg && !adv;
    assign take       = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (adv)
        begin
            in_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (adv)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg <= item;
        end
        if (adv)
        begin
            res_reg <= core_res;
        end
    end

    tpslm_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .item  (in_reg),
        .res   (core_res)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ hw/rtl/tpslm_core.sv @@
// Counter state of the monitor and the single-pass update for one item.
// Depends on tpslm_pkg and the assertion macro header.
`include "twin_presence_shelf_life_monitor_top_macros.svh"

module tpslm_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  tpslm_pkg::item_t item,
    output tpslm_pkg::result_t res
);

    logic [15:0] own_reg, own_next;
    logic [15:0] twin_reg, twin_next;
    logic [14:0] lost_reg, lost_next;
    logic [15:0] fresh_reg, fresh_next;
    logic [31:0] run_reg, run_next;
    logic [1:0]  ev;
    logic [1:0]  st;

    always_comb
    begin
        own_next   = own_reg;
        twin_next  = twin_reg;
        lost_next  = lost_reg;
        fresh_next = fresh_reg;
        run_next   = run_reg;
        ev         = tpslm_pkg::EV_NONE;
        st         = tpslm_pkg::ST_OK;
        case (item.action)
            tpslm_pkg::ACT_TICK:
            begin
                fresh_next = tpslm_pkg::sat_inc16(fresh_reg);
                own_next   = tpslm_pkg::sat_inc16(own_reg);
                if (item.twin_present)
                begin
                    twin_next = tpslm_pkg::sat_inc16(twin_reg);
                    if (twin_next > tpslm_pkg::PRESENT_EVENT_AT)
                    begin
                        lost_next = '0;
                    end
                    else if (twin_next == tpslm_pkg::PRESENT_EVENT_AT)
                    begin
                        ev = tpslm_pkg::EV_LINK_ERR;
                    end
                end
                else
                begin
                    lost_next = lost_reg + 15'd1;
                    if (lost_next >= tpslm_pkg::LOST_DROP_AT)
                    begin
                        twin_next = '0;
                        run_next  = '0;
                        if (lost_next == tpslm_pkg::LOST_CLEAR_AT)
                        begin
                            ev = tpslm_pkg::EV_CLEARED;
                        end
                        else if (lost_next > tpslm_pkg::LOST_FOLD_ABOVE)
                        begin
                            lost_next = tpslm_pkg::LOST_FOLD_TO;
                        end
                    end
                end
                // The correction pass runs once in every 256 seconds of own uptime.
                if (own_next[7:0] == tpslm_pkg::CORRECT_PHASE)
                begin
                    if (own_next > tpslm_pkg::FOLD_ABOVE)
                    begin
                        own_next = tpslm_pkg::FOLD_TO;
                    end
                    if (twin_next > tpslm_pkg::FOLD_ABOVE)
                    begin
                        twin_next = tpslm_pkg::FOLD_TO;
                    end
                    if (!item.twin_present || fresh_next > tpslm_pkg::STALE_ABOVE)
                    begin
                        twin_next = '0;
                        run_next  = '0;
                    end
                end
            end
            tpslm_pkg::ACT_HEARTBEAT:
            begin
                if (!item.length_ok)
                begin
                    st = tpslm_pkg::ST_BAD_LEN;
                end
                else
                begin
                    if ({1'b0, item.peer_seen_uptime} > ({1'b0, own_reg} + tpslm_pkg::ADOPT_MARGIN)
                        && own_reg < tpslm_pkg::ADOPT_LIMIT)
                    begin
                        own_next = item.peer_seen_uptime;
                    end
                    if ({1'b0, item.peer_own_uptime} > ({1'b0, twin_reg} + tpslm_pkg::ADOPT_MARGIN)
                        && twin_reg < tpslm_pkg::ADOPT_LIMIT)
                    begin
                        twin_next = item.peer_own_uptime;
                    end
                    run_next   = item.peer_run_seconds;
                    fresh_next = '0;
                    st = (item.peer_run_seconds < tpslm_pkg::WARMUP_BELOW) ?
                         tpslm_pkg::ST_WARMUP : tpslm_pkg::ST_OK;
                end
            end
            tpslm_pkg::ACT_FORCE:
            begin
                if (own_reg < item.force_value)
                begin
                    own_next = item.force_value;
                end
            end
            tpslm_pkg::ACT_REPORT:
            begin
                if (fresh_reg > tpslm_pkg::FOLD_ABOVE)
                begin
                    fresh_next = tpslm_pkg::FOLD_ABOVE;
                end
            end
            tpslm_pkg::ACT_OFFLINE:
            begin
                run_next = '0;
            end
            default:
            begin
                own_next = own_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg   <= '0;
            twin_reg  <= '0;
            lost_reg  <= tpslm_pkg::LOST_RESET;
            fresh_reg <= '0;
            run_reg   <= '0;
        end
        else if (en)
        begin
            own_reg   <= own_next;
            twin_reg  <= twin_next;
            lost_reg  <= lost_next;
            fresh_reg <= fresh_next;
            run_reg   <= run_next;
        end
    end

    assign res.event_code  = ev;
    assign res.status      = st;
    assign res.own_uptime  = own_next;
    assign res.twin_uptime = twin_next;
    assign res.freshness   = fresh_next;
    assign res.twin_run    = run_next;

    // The loss counter is folded before it can pass the fold threshold.
    `TPSLM_ASSERT_SAME(a_lost_bounded, clk, rst_n, 1'b1, lost_reg <= tpslm_pkg::LOST_FOLD_ABOVE)
    // A clear event always drops the partner state.
    `TPSLM_ASSERT_NEXT(a_clear_drops, clk, rst_n,
        en && item.action == tpslm_pkg::ACT_TICK && ev == tpslm_pkg::EV_CLEARED,
        twin_reg == '0 && run_reg == '0)
    // A good heartbeat restarts the freshness count.
    `TPSLM_ASSERT_NEXT(a_hb_fresh, clk, rst_n,
        en && item.action == tpslm_pkg::ACT_HEARTBEAT && item.length_ok,
        fresh_reg == '0)

endmodule

@@ verif/tpslm_checker.sv @@
// Checker for the twin presence and shelf-life monitor: watches both channels,
// predicts every result beat from the accepted item beats and compares them field by field.
// Depends on tpslm_pkg for the beat types, codes and constants.
module tpslm_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  tpslm_pkg::item_t   item,
    input  logic               res_valid,
    input  logic               res_stall,
    input  tpslm_pkg::result_t res,
    output int                 mismatch_count,
    output int                 pending_count
);

    logic [15:0] own_secs;
    logic [15:0] twin_secs;
    logic [15:0] fresh_secs;
    logic [14:0] lost_ticks;
    logic [31:0] twin_run_secs;

    tpslm_pkg::result_t expected_results[$];

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hffff) ? v : v + 16'd1;
    endfunction

    function automatic tpslm_pkg::result_t advance_monitor(input tpslm_pkg::item_t b);
        tpslm_pkg::result_t r;
        logic [1:0] ev;
        logic [1:0] st;
        ev = tpslm_pkg::EV_NONE;
        st = tpslm_pkg::ST_OK;
        case (b.action)
            tpslm_pkg::ACT_TICK:
            begin
                fresh_secs = bump(fresh_secs);
                own_secs = bump(own_secs);
                if (b.twin_present)
                begin
                    twin_secs = bump(twin_secs);
                    if (twin_secs > tpslm_pkg::PRESENT_EVENT_AT)
                        lost_ticks = '0;
                    else if (twin_secs == tpslm_pkg::PRESENT_EVENT_AT)
                        ev = tpslm_pkg::EV_LINK_ERR;
                end
                else
                begin
                    lost_ticks = lost_ticks + 15'd1;
                    if (lost_ticks >= tpslm_pkg::LOST_DROP_AT)
                    begin
                        twin_secs = '0;
                        twin_run_secs = '0;
                        if (lost_ticks == tpslm_pkg::LOST_CLEAR_AT)
                            ev = tpslm_pkg::EV_CLEARED;
                        else if (lost_ticks > tpslm_pkg::LOST_FOLD_ABOVE)
                            lost_ticks = tpslm_pkg::LOST_FOLD_TO;
                    end
                end
                // The correction pass runs once every 256 seconds of own uptime.
                if (own_secs[7:0] == tpslm_pkg::CORRECT_PHASE)
                begin
                    if (own_secs > tpslm_pkg::FOLD_ABOVE)
                        own_secs = tpslm_pkg::FOLD_TO;
                    if (twin_secs > tpslm_pkg::FOLD_ABOVE)
                        twin_secs = tpslm_pkg::FOLD_TO;
                    if (!b.twin_present || fresh_secs > tpslm_pkg::STALE_ABOVE)
                    begin
                        twin_secs = '0;
                        twin_run_secs = '0;
                    end
                end
            end
            tpslm_pkg::ACT_HEARTBEAT:
            begin
                if (!b.length_ok)
                    st = tpslm_pkg::ST_BAD_LEN;
                else
                begin
                    if ({1'b0, b.peer_seen_uptime} > {1'b0, own_secs} + tpslm_pkg::ADOPT_MARGIN
                        && own_secs < tpslm_pkg::ADOPT_LIMIT)
                        own_secs = b.peer_seen_uptime;
                    if ({1'b0, b.peer_own_uptime} > {1'b0, twin_secs} + tpslm_pkg::ADOPT_MARGIN
                        && twin_secs < tpslm_pkg::ADOPT_LIMIT)
                        twin_secs = b.peer_own_uptime;
                    twin_run_secs = b.peer_run_seconds;
                    fresh_secs = '0;
                    st = (twin_run_secs < tpslm_pkg::WARMUP_BELOW) ?
                         tpslm_pkg::ST_WARMUP : tpslm_pkg::ST_OK;
                end
            end
            tpslm_pkg::ACT_FORCE:
            begin
                if (own_secs < b.force_value)
                    own_secs = b.force_value;
            end
            tpslm_pkg::ACT_REPORT:
            begin
                if (fresh_secs > tpslm_pkg::FOLD_ABOVE)
                    fresh_secs = tpslm_pkg::FOLD_ABOVE;
            end
            tpslm_pkg::ACT_OFFLINE:
            begin
                twin_run_secs = '0;
            end
            default:
            begin
            end
        endcase
        r.event_code = ev;
        r.status = st;
        r.own_uptime = own_secs;
        r.twin_uptime = twin_secs;
        r.freshness = fresh_secs;
        r.twin_run = twin_run_secs;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tpslm_pkg::result_t want;
        if (!rst_n)
        begin
            own_secs = '0;
            twin_secs = '0;
            fresh_secs = '0;
            lost_ticks = tpslm_pkg::LOST_RESET;
            twin_run_secs = '0;
            expected_results.delete();
            mismatch_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_results.push_back(advance_monitor(item));
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("Unexpected result beat: ev=%0d st=%0d own=%0d twin=%0d",
                            res.event_code, res.status, res.own_uptime, res.twin_uptime);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.event_code !== want.event_code || res.status !== want.status
                        || res.own_uptime !== want.own_uptime
                        || res.twin_uptime !== want.twin_uptime
                        || res.freshness !== want.freshness
                        || res.twin_run !== want.twin_run)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display({"Mismatch expected: ev=%0d st=%0d own=%0d twin=%0d",
                                      " fresh=%0d run=%0h"},
                                want.event_code, want.status, want.own_uptime,
                                want.twin_uptime, want.freshness, want.twin_run);
                            $display({"         actual:   ev=%0d st=%0d own=%0d twin=%0d",
                                      " fresh=%0d run=%0h"},
                                res.event_code, res.status, res.own_uptime,
                                res.twin_uptime, res.freshness, res.twin_run);
                        end
                        mismatch_count++;
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
// Top of the monitor testbench: clock, reset, item stimulus, result back-pressure and verdict.
// Depends on tpslm_pkg, twin_presence_shelf_life_monitor_top and tpslm_checker.
module testbench;

    localparam int RANDOM_BEATS   = 800;
    localparam int SOAK_TICKS     = 40;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 1000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    tpslm_pkg::item_t   item = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    tpslm_pkg::result_t res;

    int mismatch_total;
    int outstanding;
    int quiet_cycles = 0;
    int random_beats = 0;
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_long = 1'b0;

    always #5 clk = ~clk;

    twin_presence_shelf_life_monitor_top DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    tpslm_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res            (res),
        .mismatch_count (mismatch_total),
        .pending_count  (outstanding)
    );

    function automatic tpslm_pkg::item_t compose_beat(input logic [2:0] act,
                                                      input logic present,
                                                      input logic len_ok,
                                                      input logic [15:0] peer_own,
                                                      input logic [15:0] peer_seen,
                                                      input logic [31:0] run,
                                                      input logic [15:0] force_to);
        tpslm_pkg::item_t b;
        b.action = act;
        b.twin_present = present;
        b.length_ok = len_ok;
        b.peer_own_uptime = peer_own;
        b.peer_seen_uptime = peer_seen;
        b.peer_run_seconds = run;
        b.force_value = force_to;
        return b;
    endfunction

    // Own uptime must stay below the adoption limit through the random part, so the
    // values that can raise it are kept small there; full range comes at the end.
    function automatic tpslm_pkg::item_t random_beat(input logic [2:0] act,
                                                     input bit full_range);
        tpslm_pkg::item_t b;
        b.action = act;
        b.twin_present = 1'($urandom_range(0, 1));
        b.length_ok = ($urandom_range(0, 7) != 0);
        b.peer_own_uptime = 16'($urandom);
        b.peer_seen_uptime = full_range ? 16'($urandom) : 16'($urandom_range(0, 1500));
        b.peer_run_seconds = $urandom_range(0, 1) ? $urandom_range(0, 139) : $urandom;
        b.force_value = full_range ? 16'($urandom) : 16'($urandom_range(0, 1500));
        return b;
    endfunction

    // Entered and left at a falling edge; valid stays high between back-to-back beats.
    task automatic send_beat(input tpslm_pkg::item_t b);
        int gap;
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= b;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    task automatic send_ticks(input int count, input logic present);
        tpslm_pkg::item_t b;
        for (int i = 0; i < count; i++)
        begin
            b = random_beat(tpslm_pkg::ACT_TICK, 1'b0);
            b.twin_present = present;
            send_beat(b);
            random_beats++;
        end
    endtask

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                res_stall <= 1'b0;
                hold_long = 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                res_stall <= 1'b0;
            end
            else
                res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        bit pressure_done;
        pressure_done = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Opening beats cover the heartbeat rules at their limits, the loss sequence,
        // saturation of the partner count and undefined actions.
        send_beat(compose_beat(tpslm_pkg::ACT_HEARTBEAT, 1'b1, 1'b0, 16'hffff, 16'hffff,
                               '1, '1));
        send_beat(compose_beat(tpslm_pkg::ACT_HEARTBEAT, 1'b0, 1'b1, 16'd10, 16'd10,
                               32'd69, '0));
        send_beat(compose_beat(tpslm_pkg::ACT_HEARTBEAT, 1'b0, 1'b1, 16'h6000, 16'd10,
                               32'd70, '0));
        send_beat(compose_beat(tpslm_pkg::ACT_TICK, 1'b1, 1'b0, '0, '0, '0, '0));
        send_beat(compose_beat(tpslm_pkg::ACT_HEARTBEAT, 1'b0, 1'b1, '0, 16'd12,
                               32'd500, '0));
        send_beat(compose_beat(tpslm_pkg::ACT_HEARTBEAT, 1'b1, 1'b1, 16'hffff, '0, '1, '0));
        for (int i = 0; i < 4; i++)
            send_beat(compose_beat(tpslm_pkg::ACT_TICK, 1'b0, 1'b1, '1, '1, '1, '1));
        send_beat(compose_beat(tpslm_pkg::ACT_HEARTBEAT, 1'b0, 1'b1, 16'hffff, '0, '1, '0));
        send_beat(compose_beat(tpslm_pkg::ACT_TICK, 1'b1, 1'b0, '0, '0, '0, '0));
        send_beat(compose_beat(tpslm_pkg::ACT_OFFLINE, 1'b1, 1'b1, '1, '1, '1, '1));
        send_beat(compose_beat(tpslm_pkg::ACT_REPORT, 1'b1, 1'b1, '1, '1, '1, '1));
        send_beat(compose_beat(tpslm_pkg::ACT_FORCE, 1'b0, 1'b0, '0, '0, '0, '0));
        send_beat(compose_beat(tpslm_pkg::ACT_FORCE, 1'b0, 1'b0, '0, '0, '0, 16'd500));
        send_beat(compose_beat(3'd5, 1'b1, 1'b1, '1, '1, '1, '1));
        send_beat(compose_beat(3'd6, 1'b0, 1'b1, '0, '0, '0, '0));
        send_beat(compose_beat(3'd7, 1'b1, 1'b0, '1, '0, '1, '0));

        while (random_beats < RANDOM_BEATS)
        begin
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            if (!pressure_done && random_beats > 300)
            begin
                hold_long = 1'b1;
                pressure_done = 1'b1;
            end
            case ($urandom_range(0, 9)) inside
                [0:2]: send_ticks($urandom_range(1, 14), 1'b1);
                [3:4]: send_ticks($urandom_range(1, 6), 1'b0);
                [5:6]:
                begin
                    send_beat(random_beat(tpslm_pkg::ACT_HEARTBEAT, 1'b0));
                    random_beats++;
                end
                7:
                begin
                    send_beat(random_beat(3'($urandom_range(tpslm_pkg::ACT_FORCE,
                                                            tpslm_pkg::ACT_OFFLINE)), 1'b0));
                    random_beats++;
                end
                8:
                begin
                    send_beat(random_beat(3'($urandom_range(0, 7)), 1'b0));
                    random_beats++;
                end
                default:
                begin
                    repeat ($urandom_range(3, 8))
                    begin
                        send_beat(random_beat(3'($urandom_range(tpslm_pkg::ACT_TICK,
                                                                tpslm_pkg::ACT_OFFLINE)),
                                              1'b0));
                        random_beats++;
                    end
                end
            endcase
        end

        // The closing beats run with no idling on either side: ticks with the partner
        // mostly absent, then full-range values and own uptime driven into saturation.
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        for (int i = 0; i < SOAK_TICKS; i++)
            send_beat(compose_beat(tpslm_pkg::ACT_TICK, ($urandom_range(0, 15) == 0), 1'b0,
                                   '0, '0, '0, '0));
        send_beat(compose_beat(tpslm_pkg::ACT_REPORT, 1'b0, 1'b0, '0, '0, '0, '0));
        for (int i = 0; i < 40; i++)
            send_beat(random_beat(3'($urandom_range(tpslm_pkg::ACT_TICK,
                                                    tpslm_pkg::ACT_OFFLINE)), 1'b1));
        send_beat(compose_beat(tpslm_pkg::ACT_FORCE, 1'b0, 1'b0, '0, '0, '0, 16'hffff));
        send_beat(compose_beat(tpslm_pkg::ACT_TICK, 1'b1, 1'b0, '0, '0, '0, '0));
        send_beat(compose_beat(tpslm_pkg::ACT_TICK, 1'b0, 1'b0, '0, '0, '0, '0));
        item_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatch_total == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ twin_presence_shelf_life_monitor_top.f @@
+incdir+hw/rtl
hw/rtl/tpslm_pkg.sv
hw/rtl/tpslm_core.sv
hw/rtl/twin_presence_shelf_life_monitor_top.sv
verif/tpslm_checker.sv
verif/testbench.sv
